[src/jtl_pkg.sv]
// Shared types and constants of the JSON token lexer.
// No dependencies; every other file of the block imports this package.
package jtl_pkg;

  typedef logic [3:0] kind_t;

  localparam kind_t KIND_LBRACE   = 4'd0;
  localparam kind_t KIND_RBRACE   = 4'd1;
  localparam kind_t KIND_LBRACKET = 4'd2;
  localparam kind_t KIND_RBRACKET = 4'd3;
  localparam kind_t KIND_COMMA    = 4'd4;
  localparam kind_t KIND_COLON    = 4'd5;
  localparam kind_t KIND_STRING   = 4'd6;
  localparam kind_t KIND_NUMBER   = 4'd7;
  localparam kind_t KIND_TRUE     = 4'd8;
  localparam kind_t KIND_FALSE    = 4'd9;
  localparam kind_t KIND_END_OK   = 4'd10;
  localparam kind_t KIND_END_ERR  = 4'd11;

  // Characters the lexer recognises
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_POINT    = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_R        = 8'h72;
  localparam logic [7:0] CH_U        = 8'h75;
  localparam logic [7:0] CH_E        = 8'h65;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_A        = 8'h61;
  localparam logic [7:0] CH_L        = 8'h6C;
  localparam logic [7:0] CH_S        = 8'h73;

  localparam logic [5:0]  NUMBER_MAX_CHARS = 6'd33;
  localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;

  // Result queue: room for two runs of two results
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_PTR_BITS = 2;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [31:0] token_count;
    logic        last_of_run;
  } result_t;

endpackage

[src/jtl_if.sv]
// Channel interfaces of the JSON token lexer: text bytes in, tokens out.
// Depends on jtl_pkg for the kind type.
interface jtl_text_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] text_byte;

  modport source (output valid, func, text_byte, input ready);
  modport sink   (input valid, func, text_byte, output ready);
endinterface

interface jtl_token_if import jtl_pkg::*;;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [31:0] range_start;
  logic [31:0] range_end;
  logic [31:0] token_count;
  logic        last_of_run;

  modport source (output valid, kind, range_start, range_end, token_count, last_of_run,
                  input ready);
  modport sink   (input valid, kind, range_start, range_end, token_count, last_of_run,
                  output ready);
endinterface

[src/jtl_core.sv]
// Lexer state and single-pass token logic: up to two results per byte.
// Depends on jtl_pkg.
module jtl_core import jtl_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       func,
  input  logic [7:0] text_byte,
  output logic [1:0] res_n,
  output result_t    res0,
  output result_t    res1
);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_STRING  = 3'd1;
  localparam logic [2:0] MODE_ESCAPE  = 3'd2;
  localparam logic [2:0] MODE_NUMBER  = 3'd3;
  localparam logic [2:0] MODE_KEYWORD = 3'd4;
  localparam logic [2:0] MODE_ERROR   = 3'd5;

  typedef logic [POSITION_BITS-1:0] pos_t;

  logic [2:0]  mode, mode_next;
  pos_t        pos, pos_next;
  pos_t        tbeg, tbeg_next;
  logic        point, point_next;
  logic [5:0]  nlen, nlen_next;
  logic        kfalse, kfalse_next;
  logic [2:0]  kstep, kstep_next;
  logic [31:0] tok, tok_next;

  logic [1:0]  n;
  kind_t       k0, k1;
  pos_t        s0, e0, s1, e1;
  logic        ia_emit;
  kind_t       ia_kind;
  logic [2:0]  ia_mode;
  logic        run_idle, idle_slot;
  logic        kw_ok;
  logic [2:0]  kw_len;
  logic [5:0]  nlen_inc;
  logic [31:0] c0, c1;

  function automatic logic [7:0] kw_char(input logic is_false, input logic [2:0] step);
    logic [7:0] ch;
    ch = CH_E;
    if (is_false) begin
      case (step)
        3'd0: ch = CH_F;
        3'd1: ch = CH_A;
        3'd2: ch = CH_L;
        3'd3: ch = CH_S;
        default: ch = CH_E;
      endcase
    end else begin
      case (step)
        3'd0: ch = CH_T;
        3'd1: ch = CH_R;
        3'd2: ch = CH_U;
        default: ch = CH_E;
      endcase
    end
    return ch;
  endfunction

  function automatic logic [31:0] count_up(input logic [31:0] c, input kind_t k);
    return (k < KIND_END_OK && c != COUNT_MAX) ? c + 32'd1 : c;
  endfunction

  assign kw_len   = kfalse ? 3'd5 : 3'd4;
  assign kw_ok    = (kstep < kw_len) && (text_byte == kw_char(kfalse, kstep));
  assign nlen_inc = nlen + 6'd1;

  // What a byte does between tokens
  always_comb begin
    ia_emit = 1'b0;
    ia_kind = KIND_END_ERR;
    ia_mode = MODE_ERROR;
    case (text_byte) inside
      CH_SPACE, CH_TAB, CH_LF, CH_CR: ia_mode = MODE_IDLE;
      CH_LBRACE: begin
        ia_emit = 1'b1; ia_kind = KIND_LBRACE; ia_mode = MODE_IDLE;
      end
      CH_RBRACE: begin
        ia_emit = 1'b1; ia_kind = KIND_RBRACE; ia_mode = MODE_IDLE;
      end
      CH_LBRACKET: begin
        ia_emit = 1'b1; ia_kind = KIND_LBRACKET; ia_mode = MODE_IDLE;
      end
      CH_RBRACKET: begin
        ia_emit = 1'b1; ia_kind = KIND_RBRACKET; ia_mode = MODE_IDLE;
      end
      CH_COMMA: begin
        ia_emit = 1'b1; ia_kind = KIND_COMMA; ia_mode = MODE_IDLE;
      end
      CH_COLON: begin
        ia_emit = 1'b1; ia_kind = KIND_COLON; ia_mode = MODE_IDLE;
      end
      CH_QUOTE:                   ia_mode = MODE_STRING;
      CH_T, CH_F:                 ia_mode = MODE_KEYWORD;
      CH_POINT, [CH_ZERO:CH_NINE]: ia_mode = MODE_NUMBER;
      default: begin
        ia_emit = 1'b1; ia_kind = KIND_END_ERR; ia_mode = MODE_ERROR;
      end
    endcase
  end

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    tbeg_next   = tbeg;
    point_next  = point;
    nlen_next   = nlen;
    kfalse_next = kfalse;
    kstep_next  = kstep;
    n           = 2'd0;
    k0          = KIND_END_ERR;
    s0          = '0;
    e0          = '0;
    k1          = KIND_END_ERR;
    s1          = '0;
    e1          = '0;
    run_idle    = 1'b0;
    idle_slot   = 1'b0;
    if (fire) begin
      if (func) begin
        n = 2'd1;
        unique case (mode)
          MODE_IDLE: k0 = KIND_END_OK;
          MODE_NUMBER: begin
            n = 2'd2; k0 = KIND_NUMBER; s0 = tbeg; e0 = pos; k1 = KIND_END_OK;
          end
          MODE_STRING, MODE_ESCAPE: begin
            n = 2'd2; k0 = KIND_STRING; s0 = tbeg; e0 = tbeg; k1 = KIND_END_ERR;
          end
          default: k0 = KIND_END_ERR;
        endcase
        mode_next   = MODE_IDLE;
        pos_next    = '0;
        tbeg_next   = '0;
        point_next  = 1'b0;
        nlen_next   = '0;
        kfalse_next = 1'b0;
        kstep_next  = '0;
      end else begin
        pos_next = pos + pos_t'(1);
        unique case (mode)
          MODE_IDLE: run_idle = 1'b1;
          MODE_STRING: begin
            if (text_byte == CH_QUOTE) begin
              n = 2'd1; k0 = KIND_STRING; s0 = tbeg; e0 = pos;
              if (pos == tbeg) begin
                n = 2'd2; k1 = KIND_END_ERR; mode_next = MODE_ERROR;
              end else begin
                mode_next = MODE_IDLE;
              end
            end else if (text_byte == CH_BSLASH) begin
              mode_next = MODE_ESCAPE;
            end
          end
          MODE_ESCAPE: mode_next = MODE_STRING;
          MODE_NUMBER: begin
            if ((text_byte >= CH_ZERO && text_byte <= CH_NINE) ||
                (text_byte == CH_POINT && !point)) begin
              if (text_byte == CH_POINT) point_next = 1'b1;
              nlen_next = nlen_inc;
              if (nlen_inc >= NUMBER_MAX_CHARS) begin
                n = 2'd1; k0 = KIND_NUMBER; s0 = tbeg; e0 = pos + pos_t'(1);
                mode_next = MODE_IDLE;
              end
            end else begin
              // close the number, then treat the byte as between tokens
              n = 2'd1; k0 = KIND_NUMBER; s0 = tbeg; e0 = pos;
              run_idle  = 1'b1;
              idle_slot = 1'b1;
            end
          end
          MODE_KEYWORD: begin
            if (kw_ok) begin
              kstep_next = kstep + 3'd1;
              if (kstep + 3'd1 == kw_len) begin
                n = 2'd1; k0 = kfalse ? KIND_FALSE : KIND_TRUE;
                mode_next = MODE_IDLE;
              end
            end else begin
              n = 2'd1; k0 = KIND_END_ERR; mode_next = MODE_ERROR;
            end
          end
          default: ;
        endcase
        if (run_idle) begin
          mode_next = ia_mode;
          if (ia_mode == MODE_STRING) tbeg_next = pos + pos_t'(1);
          if (ia_mode == MODE_KEYWORD) begin
            kfalse_next = (text_byte == CH_F);
            kstep_next  = 3'd1;
          end
          if (ia_mode == MODE_NUMBER) begin
            tbeg_next  = pos;
            point_next = (text_byte == CH_POINT);
            nlen_next  = 6'd1;
          end
          if (ia_emit) begin
            if (idle_slot) begin
              n = 2'd2; k1 = ia_kind;
            end else begin
              n = 2'd1; k0 = ia_kind;
            end
          end
        end
      end
    end
  end

  assign c0 = count_up(tok, k0);
  assign c1 = count_up(c0, k1);

  always_comb begin
    tok_next = tok;
    if (fire) begin
      if (func) tok_next = '0;
      else if (n == 2'd2) tok_next = c1;
      else if (n == 2'd1) tok_next = c0;
    end
  end

  assign res_n = n;
  assign res0  = '{kind: k0, range_start: 32'(s0), range_end: 32'(e0),
                   token_count: c0, last_of_run: (n == 2'd1)};
  assign res1  = '{kind: k1, range_start: 32'(s1), range_end: 32'(e1),
                   token_count: c1, last_of_run: 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      pos    <= '0;
      tbeg   <= '0;
      point  <= 1'b0;
      nlen   <= '0;
      kfalse <= 1'b0;
      kstep  <= '0;
      tok    <= '0;
    end else begin
      mode   <= mode_next;
      pos    <= pos_next;
      tbeg   <= tbeg_next;
      point  <= point_next;
      nlen   <= nlen_next;
      kfalse <= kfalse_next;
      kstep  <= kstep_next;
      tok    <= tok_next;
    end
  end

  // Token count only falls at the end of a buffer
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (fire && !func) |=> tok >= $past(tok))
    else $error("token count fell on a data byte");

endmodule

[src/jtl_resq.sv]
// Small result queue: takes up to two results a cycle, hands out one when popped.
// Depends on jtl_pkg.
module jtl_resq import jtl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  result_t    push0,
  input  result_t    push1,
  output logic       room,
  output logic       head_valid,
  input  logic       pop,
  output result_t    head
);

  localparam logic [RESQ_PTR_BITS:0] DEPTH = (RESQ_PTR_BITS+1)'(RESQ_DEPTH);

  result_t                  entries [RESQ_DEPTH];
  logic [RESQ_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [RESQ_PTR_BITS:0]   count;

  assign room       = count <= DEPTH - (RESQ_PTR_BITS+1)'(2);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) entries[wr_ptr] <= push0;
    if (push_n == 2'd2) entries[wr_ptr + RESQ_PTR_BITS'(1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RESQ_PTR_BITS'(push_n);
      if (pop) rd_ptr <= rd_ptr + RESQ_PTR_BITS'(1);
      count  <= count + (RESQ_PTR_BITS+1)'(push_n) - (RESQ_PTR_BITS+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count <= DEPTH)
    else $error("result queue overflow");

endmodule

[src/json_token_lexer.sv]
// Top level of the streaming JSON token lexer.
// Depends on jtl_pkg, jtl_if, jtl_core and jtl_resq.
//
//   channel        role   payload
//   text_stream    sink   func, text_byte
//   token_stream   source kind, range_start, range_end, token_count, last_of_run
//
// One byte is accepted per cycle unless the queue stalls it; it is held in the
// input register, then lexed in a single pass into zero, one or two results for
// the result queue. The output side delivers one result per cycle while ready,
// so a byte that causes two results costs two output transfers; sustained rate
// is one byte per clock whenever results are taken as fast as they are made.
// rst is synchronous and clears the lexer state, queue and input register.
// A stalled output holds the queue; once it lacks room for two results the
// input register holds and text_stream.ready drops.
module json_token_lexer import jtl_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input logic clk,
  input logic rst,
  jtl_text_if.sink    text_stream,
  jtl_token_if.source token_stream
);

  // Input register
  logic       in_valid;
  logic       in_func;
  logic [7:0] in_byte;

  logic       core_fire;
  logic       q_room;
  logic [1:0] res_n;
  result_t    res0, res1, head;
  logic       head_valid;

  // Lex the held byte only when the queue can take a full run of two
  assign core_fire         = in_valid && q_room;
  assign text_stream.ready = !in_valid || core_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text_stream.ready) begin
      in_valid <= text_stream.valid;
    end
  end

  // Payload: load on every accepted transaction, hold otherwise
  always_ff @(posedge clk) begin
    if (text_stream.valid && text_stream.ready) begin
      in_func <= text_stream.func;
      in_byte <= text_stream.text_byte;
    end
  end

  jtl_core #(.POSITION_BITS(POSITION_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (core_fire),
    .func      (in_func),
    .text_byte (in_byte),
    .res_n     (res_n),
    .res0      (res0),
    .res1      (res1)
  );

  jtl_resq u_resq (
    .clk        (clk),
    .rst        (rst),
    .push_n     (res_n),
    .push0      (res0),
    .push1      (res1),
    .room       (q_room),
    .head_valid (head_valid),
    .pop        (token_stream.valid && token_stream.ready),
    .head       (head)
  );

  assign token_stream.valid       = head_valid;
  assign token_stream.kind        = head.kind;
  assign token_stream.range_start = head.range_start;
  assign token_stream.range_end   = head.range_end;
  assign token_stream.token_count = head.token_count;
  assign token_stream.last_of_run = head.last_of_run;

  // A held byte that could not be lexed stays put for the next cycle
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !core_fire) |=> (in_valid && $stable(in_byte) && $stable(in_func)))
    else $error("input register lost a byte");

  // The end marker always closes the buffer with at least one result
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    (core_fire && in_func) |-> (res_n != 2'd0))
    else $error("end marker produced no result");

  // Exactly the final result of a run carries last_of_run
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (core_fire && res_n == 2'd2) |-> (!res0.last_of_run && res1.last_of_run))
    else $error("last_of_run misplaced");

endmodule

[bench/json_token_lexer_tb.sv]
// Self-checking bench for json_token_lexer: directed table, then random JSON-like documents.
// Depends on jtl_pkg and the jtl_text_if / jtl_token_if channel interfaces of the block.
module json_token_lexer_tb;
  import jtl_pkg::*;

  localparam logic FN_DATA = 1'b0;
  localparam logic FN_END  = 1'b1;
  localparam logic PRED    = 1'b0;
  localparam logic TYPED   = 1'b1;

  localparam int RANDOM_ITEMS    = 1050;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int TAIL_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef enum logic [2:0] {
    LX_IDLE, LX_STRING, LX_ESCAPE, LX_NUMBER, LX_KEYWORD, LX_ERROR
  } lex_mode_e;

  // One input transaction. On typed rows kind/count give the single expected token;
  // on predicted rows they are fillers and the predictor decides.
  typedef struct packed {
    logic        func;
    logic [7:0]  text;
    logic        typed;
    kind_t       kind;
    logic [31:0] count;
  } stim_row_t;

  localparam logic [7:0] WORD_TRUE [4]   = '{CH_T, CH_R, CH_U, CH_E};
  localparam logic [7:0] WORD_FALSE [5]  = '{CH_F, CH_A, CH_L, CH_S, CH_E};
  localparam logic [7:0] PUNCT_CHARS [6] =
    '{CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_COMMA, CH_COLON};
  localparam logic [7:0] WS_CHARS [4]    = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};

  // Directed part: reset behaviour, punctuation, escapes, points, keywords, error records,
  // the byte extremes and ends of a buffer inside a number, a keyword and a string.
  localparam stim_row_t DIRECTED_ROWS [30] = '{
    '{FN_END,  8'hFF,       TYPED, KIND_END_OK,  32'd0}, // empty buffer straight out of reset
    '{FN_DATA, CH_LBRACE,   TYPED, KIND_LBRACE,  32'd1},
    '{FN_DATA, CH_QUOTE,    PRED,  KIND_END_OK,  32'd0},
    '{FN_DATA, CH_BSLASH,   PRED,  KIND_END_OK,  32'd0},
    '{FN_DATA, CH_QUOTE,    PRED,  KIND_END_OK,  32'd0}, // escaped quote stays in the string
    '{FN_DATA, CH_QUOTE,    PRED,  KIND_END_OK,  32'd0},
    '{FN_DATA, CH_COLON,    TYPED, KIND_COLON,   32'd3},
    '{FN_DATA, CH_POINT,    PRED,  KIND_END_OK,  32'd0}, // number opening with a point
    '{FN_DATA, CH_POINT,    PRED,  KIND_END_OK,  32'd0}, // second point closes, reopens
    '{FN_DATA, CH_COMMA,    PRED,  KIND_END_OK,  32'd0}, // number and comma together
    '{FN_DATA, CH_T,        PRED,  KIND_END_OK,  32'd0},
    '{FN_DATA, CH_R,        PRED,  KIND_END_OK,  32'd0},
    '{FN_DATA, CH_U,        PRED,  KIND_END_OK,  32'd0},
    '{FN_DATA, CH_E,        PRED,  KIND_END_OK,  32'd0},
    '{FN_DATA, CH_TAB,      PRED,  KIND_END_OK,  32'd0},
    '{FN_DATA, CH_NINE,     PRED,  KIND_END_OK,  32'd0},
    '{FN_END,  8'h00,       PRED,  KIND_END_OK,  32'd0}, // end closes the open number
    '{FN_DATA, CH_QUOTE,    PRED,  KIND_END_OK,  32'd0},
    '{FN_DATA, CH_QUOTE,    PRED,  KIND_END_OK,  32'd0}, // empty string, then error
    '{FN_END,  8'h55,       TYPED, KIND_END_ERR, 32'd1},
    '{FN_DATA, 8'hFF,       TYPED, KIND_END_ERR, 32'd0}, // bad character
    '{FN_END,  8'hAA,       TYPED, KIND_END_ERR, 32'd0},
    '{FN_DATA, CH_F,        PRED,  KIND_END_OK,  32'd0},
    '{FN_DATA, CH_A,        PRED,  KIND_END_OK,  32'd0},
    '{FN_DATA, 8'h00,       TYPED, KIND_END_ERR, 32'd0}, // keyword mismatch
    '{FN_END,  8'hFF,       TYPED, KIND_END_ERR, 32'd0},
    '{FN_DATA, CH_F,        PRED,  KIND_END_OK,  32'd0},
    '{FN_END,  8'h00,       TYPED, KIND_END_ERR, 32'd0}, // end inside a keyword
    '{FN_DATA, CH_QUOTE,    PRED,  KIND_END_OK,  32'd0},
    '{FN_END,  8'h7F,       PRED,  KIND_END_OK,  32'd0}  // end inside a string
  };

  logic clk = 1'b0;
  logic rst;

  jtl_text_if  text_ch ();
  jtl_token_if token_ch ();

  json_token_lexer #(.POSITION_BITS(32)) dut (
    .clk(clk),
    .rst(rst),
    .text_stream(text_ch),
    .token_stream(token_ch)
  );

  always #10 clk = ~clk;

  // Lexer state as the bench tracks it
  lex_mode_e   lex_mode;
  logic [31:0] lex_pos;
  logic [31:0] tok_begin;
  logic        pt_seen;
  logic [5:0]  num_len;
  logic        kw_false;
  logic [2:0]  kw_step;
  logic [31:0] tok_count;

  result_t   run_tokens[$];  // tokens caused by the transaction being lexed
  result_t   tokens_due[$];  // tokens still owed by the block, oldest first
  stim_row_t doc_rows[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int live_items    = 0;
  int mismatches    = 0;
  int idle_cycles   = 0;
  bit hold_request  = 1'b0;

  function automatic void clear_lexer();
    lex_mode  = LX_IDLE;
    lex_pos   = 32'd0;
    tok_begin = 32'd0;
    pt_seen   = 1'b0;
    num_len   = 6'd0;
    kw_false  = 1'b0;
    kw_step   = 3'd0;
    tok_count = 32'd0;
  endfunction

  function automatic bit is_digit_char(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // Record a token; only real tokens (not end or error records) bump the saturating count
  function automatic void put_token(kind_t k, logic [31:0] s, logic [31:0] e);
    result_t r;
    if (k <= KIND_FALSE && tok_count != COUNT_MAX) tok_count++;
    r.kind        = k;
    r.range_start = s;
    r.range_end   = e;
    r.token_count = tok_count;
    r.last_of_run = 1'b0;
    run_tokens.push_back(r);
  endfunction

  // Handle a byte that arrives between tokens
  function automatic void lex_between(logic [7:0] b, logic [31:0] p);
    case (b)
      CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
      end
      CH_LBRACE:   put_token(KIND_LBRACE, 32'd0, 32'd0);
      CH_RBRACE:   put_token(KIND_RBRACE, 32'd0, 32'd0);
      CH_LBRACKET: put_token(KIND_LBRACKET, 32'd0, 32'd0);
      CH_RBRACKET: put_token(KIND_RBRACKET, 32'd0, 32'd0);
      CH_COMMA:    put_token(KIND_COMMA, 32'd0, 32'd0);
      CH_COLON:    put_token(KIND_COLON, 32'd0, 32'd0);
      CH_QUOTE: begin
        lex_mode  = LX_STRING;
        tok_begin = p + 32'd1;
      end
      CH_T, CH_F: begin
        lex_mode = LX_KEYWORD;
        kw_false = (b == CH_F);
        kw_step  = 3'd1;
      end
      default: begin
        if (is_digit_char(b) || b == CH_POINT) begin
          lex_mode  = LX_NUMBER;
          tok_begin = p;
          pt_seen   = (b == CH_POINT);
          num_len   = 6'd1;
        end else begin
          lex_mode = LX_ERROR;
          put_token(KIND_END_ERR, 32'd0, 32'd0);
        end
      end
    endcase
  endfunction

  // Work out the tokens that one accepted transaction causes, into run_tokens
  function automatic void tokenise_item(logic f, logic [7:0] b);
    logic [31:0] p;
    logic [2:0]  word_len;
    bit          match;
    p = lex_pos;
    run_tokens.delete();
    if (f == FN_END) begin
      case (lex_mode)
        LX_IDLE: put_token(KIND_END_OK, 32'd0, 32'd0);
        LX_NUMBER: begin
          put_token(KIND_NUMBER, tok_begin, p);
          put_token(KIND_END_OK, 32'd0, 32'd0);
        end
        LX_STRING, LX_ESCAPE: begin
          put_token(KIND_STRING, tok_begin, tok_begin);
          put_token(KIND_END_ERR, 32'd0, 32'd0);
        end
        default: put_token(KIND_END_ERR, 32'd0, 32'd0);
      endcase
      clear_lexer();
    end else begin
      case (lex_mode)
        LX_IDLE: lex_between(b, p);
        LX_STRING: begin
          if (b == CH_QUOTE) begin
            put_token(KIND_STRING, tok_begin, p);
            if (p == tok_begin) begin
              put_token(KIND_END_ERR, 32'd0, 32'd0);
              lex_mode = LX_ERROR;
            end else begin
              lex_mode = LX_IDLE;
            end
          end else if (b == CH_BSLASH) begin
            lex_mode = LX_ESCAPE;
          end
        end
        LX_ESCAPE: lex_mode = LX_STRING;
        LX_NUMBER: begin
          if (is_digit_char(b) || (b == CH_POINT && !pt_seen)) begin
            if (b == CH_POINT) pt_seen = 1'b1;
            num_len = num_len + 6'd1;
            // the last allowed character closes the number on the spot
            if (num_len >= NUMBER_MAX_CHARS) begin
              put_token(KIND_NUMBER, tok_begin, p + 32'd1);
              lex_mode = LX_IDLE;
            end
          end else begin
            put_token(KIND_NUMBER, tok_begin, p);
            lex_mode = LX_IDLE;
            lex_between(b, p);
          end
        end
        LX_KEYWORD: begin
          word_len = kw_false ? 3'd5 : 3'd4;
          match = 1'b0;
          if (kw_step < word_len)
            match = (b == (kw_false ? WORD_FALSE[kw_step] : WORD_TRUE[kw_step]));
          if (match) begin
            kw_step = kw_step + 3'd1;
            if (kw_step == word_len) begin
              put_token(kw_false ? KIND_FALSE : KIND_TRUE, 32'd0, 32'd0);
              lex_mode = LX_IDLE;
            end
          end else begin
            put_token(KIND_END_ERR, 32'd0, 32'd0);
            lex_mode = LX_ERROR;
          end
        end
        default: begin
        end
      endcase
      lex_pos = p + 32'd1;
    end
    if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // Offer one transaction, hold it until accepted, then queue what it must cause
  task automatic send_item(stim_row_t row);
    result_t typed_token;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.func      <= row.func;
    text_ch.text_byte <= row.text;
    do @(posedge clk); while (text_ch.ready !== 1'b1);
    live_items++;
    tokenise_item(row.func, row.text);
    if (row.typed) begin
      typed_token = '{kind: row.kind, range_start: 32'd0, range_end: 32'd0,
                      token_count: row.count, last_of_run: 1'b1};
      run_tokens.delete();
      run_tokens.push_back(typed_token);
    end
    foreach (run_tokens[i]) tokens_due.push_back(run_tokens[i]);
  endtask

  function automatic void push_byte(logic [7:0] b);
    doc_rows.push_back('{FN_DATA, b, PRED, KIND_END_OK, 32'd0});
  endfunction

  // Build and send one buffer: mostly well-formed tokens with random content,
  // sometimes with a corrupted byte or cut short before the end marker.
  task automatic send_document();
    int          n_tokens;
    int          pick;
    int          len;
    int          point_at;
    int          cut;
    logic [7:0]  c;
    doc_rows.delete();
    n_tokens = $urandom_range(1, 14);
    repeat (n_tokens) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        push_byte(PUNCT_CHARS[$urandom_range(0, 5)]);
      end else if (pick < 45) begin
        push_byte(CH_QUOTE);
        len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
        repeat (len) begin
          if ($urandom_range(0, 6) == 0) begin
            push_byte(CH_BSLASH);
            push_byte(8'($urandom_range(0, 255)));
          end else begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
            push_byte(c);
          end
        end
        push_byte(CH_QUOTE);
      end else if (pick < 70) begin
        // now and then a long run to hit the length limit and what follows it
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
        point_at = $urandom_range(0, 2 * len);
        for (int k = 0; k < len; k++) begin
          c = CH_ZERO + 8'($urandom_range(0, 9));
          push_byte((k == point_at) ? CH_POINT : c);
        end
      end else if (pick < 85) begin
        if ($urandom_range(0, 1)) begin
          foreach (WORD_TRUE[k]) push_byte(WORD_TRUE[k]);
        end else begin
          foreach (WORD_FALSE[k]) push_byte(WORD_FALSE[k]);
        end
      end
      if (pick >= 85 || $urandom_range(0, 3) == 0) push_byte(WS_CHARS[$urandom_range(0, 3)]);
    end
    if ($urandom_range(0, 99) < 20) begin
      cut = $urandom_range(0, doc_rows.size() - 1);
      if ($urandom_range(0, 1)) doc_rows[cut].text = 8'($urandom_range(0, 255));
      else while (doc_rows.size() > cut) void'(doc_rows.pop_back());
    end
    doc_rows.push_back('{FN_END, 8'($urandom_range(0, 255)), PRED, KIND_END_OK, 32'd0});
    foreach (doc_rows[i]) send_item(doc_rows[i]);
  endtask

  // Stimulus: reset, directed table, then three idling phases of random documents
  initial begin
    clear_lexer();
    rst               <= 1'b1;
    text_ch.valid     <= 1'b0;
    text_ch.func      <= FN_DATA;
    text_ch.text_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 12;
    recv_idle_pct = 72;
    foreach (DIRECTED_ROWS[i]) send_item(DIRECTED_ROWS[i]);

    live_items = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // sender now offers every cycle, so a long hold-off backs the block up
          hold_request = 1'b1;
        end
      endcase
      while (live_items < RANDOM_ITEMS * (phase + 1) / 3) send_document();
    end
    text_ch.valid <= 1'b0;

    // drain, then give any stray token time to show up
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Token sink: random back-pressure, plus one long hold-off when asked
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    token_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        token_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (rst) token_ch.ready <= 1'b0;
      else token_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each token transaction with the oldest one owed
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && token_ch.valid === 1'b1 && token_ch.ready === 1'b1) begin
      got = '{token_ch.kind, token_ch.range_start, token_ch.range_end,
              token_ch.token_count, token_ch.last_of_run};
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("token kind %0d with nothing owed", got.kind));
      end else begin
        want = tokens_due.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.range_start !== want.range_start)
          report_mismatch($sformatf("range_start %0d, want %0d",
                                    got.range_start, want.range_start));
        if (got.range_end !== want.range_end)
          report_mismatch($sformatf("range_end %0d, want %0d", got.range_end, want.range_end));
        if (got.token_count !== want.token_count)
          report_mismatch($sformatf("token_count %0d, want %0d",
                                    got.token_count, want.token_count));
        if (got.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %0b, want %0b",
                                    got.last_of_run, want.last_of_run));
      end
    end
  end

  // Watchdog: give up once neither channel has moved a transaction for too long
  always @(posedge clk) begin
    if ((text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

[filelist.f]
src/jtl_pkg.sv
src/jtl_if.sv
src/jtl_core.sv
src/jtl_resq.sv
src/json_token_lexer.sv
bench/json_token_lexer_tb.sv
